@@ hdl/nsd_pkg.sv @@
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants of the NodeId byte stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nsd_pkg;

  localparam int unsigned ResultDepth = 4;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_EXPANDED_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXTENDED_FORMATS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STRING_LENGTH = 2'd2;

  localparam logic [30:0] MaxStringLengthReset = 31'd4096;
  localparam logic [31:0] OpaqueMaxLength      = 32'd16;
  localparam logic [30:0] GuidLength           = 31'd16;

  localparam int unsigned FlagUri    = 7;
  localparam int unsigned FlagServer = 6;

  localparam logic [3:0] FMT_TWO_BYTE  = 4'h0;
  localparam logic [3:0] FMT_FOUR_BYTE = 4'h1;
  localparam logic [3:0] FMT_NUMERIC   = 4'h2;
  localparam logic [3:0] FMT_STRING    = 4'h3;
  localparam logic [3:0] FMT_GUID      = 4'h4;
  localparam logic [3:0] FMT_OPAQUE    = 4'h5;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } rec_kind_e;

  typedef enum logic [1:0] {
    ID_NUMERIC = 2'd0,
    ID_STRING  = 2'd1,
    ID_GUID    = 2'd2,
    ID_OPAQUE  = 2'd3
  } id_kind_e;

  typedef enum logic [3:0] {
    PH_MASK  = 4'd0,
    PH_ID8   = 4'd1,
    PH_NS8   = 4'd2,
    PH_ID16  = 4'd3,
    PH_NS16  = 4'd4,
    PH_ID32  = 4'd5,
    PH_SLEN  = 4'd6,
    PH_SDATA = 4'd7,
    PH_GUID  = 4'd8,
    PH_OLEN  = 4'd9,
    PH_ODATA = 4'd10,
    PH_ULEN  = 4'd11,
    PH_UDATA = 4'd12,
    PH_SRV   = 4'd13
  } phase_e;

  typedef struct packed {
    logic        expanded;
    logic        extended;
    logic [30:0] max_len;
  } nsd_cfg_t;

  typedef struct packed {
    rec_kind_e   kind;
    logic [7:0]  payload_byte;
    logic        payload_source;
    logic [1:0]  id_kind;
    logic [15:0] ns_index;
    logic [31:0] numeric_id;
    logic [31:0] id_length;
    logic [31:0] uri_length;
    logic [31:0] srv_index;
  } nsd_rec_t;

endpackage

`default_nettype wire

@@ hdl/nodeid_binary_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// nodeid_binary_stream_decoder_core
// Decodes binary (expanded) NodeIds from a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per transfer (in_valid_i, in_stall_o),
//   restart_i marks the byte as a fresh mask byte.
//   Output channel: one record per transfer (out_valid_o, out_stall_i):
//   payload byte, NodeId complete, or decode error.
//   Config channel: cfg_valid_i/cfg_ready_o, always ready, written while idle.
//   Queueing: a record enters the queue the cycle after its byte is taken and
//   is offered once it reaches the queue head. Throughput: one byte per cycle
//   while in_stall_o is low; the decode step sits between the input handshake
//   and a 4-entry result queue. A byte that ends an item with a payload byte
//   yields two records, drained one per cycle while out_stall_i is low. in_stall_o
//   rises when the queue has fewer than two free entries, backing up the input.
//   Reset: decoder expects a mask byte, queue is empty, registers return to
//   expanded_mode 0, extended_formats 1, max_string_length 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module nodeid_binary_stream_decoder_core #(
  parameter int unsigned FifoDepth = nsd_pkg::ResultDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         restart_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        record_kind_o,
  output logic [7:0]                        payload_byte_o,
  output logic                              payload_source_o,
  output logic [1:0]                        identifier_kind_o,
  output logic [15:0]                       ns_index_o,
  output logic [31:0]                       numeric_id_o,
  output logic signed [31:0]                identifier_length_o,
  output logic signed [31:0]                uri_length_o,
  output logic [31:0]                       srv_index_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [nsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nsd_pkg::CfgDataW-1:0] cfg_data_i
);
  import nsd_pkg::*;

  nsd_cfg_t   cfg_q;
  logic       accept, pop, full;
  logic [1:0] push_n;
  nsd_rec_t   rec0, rec1, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expanded <= 1'b0;
      cfg_q.extended <= 1'b1;
      cfg_q.max_len  <= MaxStringLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_EXPANDED_MODE:     cfg_q.expanded <= cfg_data_i[0];
        CFG_EXTENDED_FORMATS:  cfg_q.extended <= cfg_data_i[0];
        CFG_MAX_STRING_LENGTH: cfg_q.max_len  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  nsd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .push_n_o    (push_n),
    .rec0_o      (rec0),
    .rec1_o      (rec1)
  );

  nsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .rec0_i   (rec0),
    .rec1_i   (rec1),
    .pop_i    (pop),
    .full_o   (full),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign record_kind_o       = head.kind;
  assign payload_byte_o      = head.payload_byte;
  assign payload_source_o    = head.payload_source;
  assign identifier_kind_o   = head.id_kind;
  assign ns_index_o          = head.ns_index;
  assign numeric_id_o        = head.numeric_id;
  assign identifier_length_o = $signed(head.id_length);
  assign uri_length_o        = $signed(head.uri_length);
  assign srv_index_o         = head.srv_index;

endmodule

`default_nettype wire

@@ hdl/nsd_step.sv @@
// ----------------------------------------------------------------------------
// nsd_step
// Per-byte decode state machine; yields up to two result records per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nsd_pkg::nsd_cfg_t cfg_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              restart_i,
  output logic [1:0]             push_n_o,
  output nsd_pkg::nsd_rec_t      rec0_o,
  output nsd_pkg::nsd_rec_t      rec1_o
);
  import nsd_pkg::*;

  phase_e      phase_q, phase_d, cur;
  logic [7:0]  mask_q, mask_d;
  logic [30:0] cnt_q, cnt_d, cnt_inc, cnt_dec;
  logic [15:0] ns_q, ns_d;
  logic [31:0] num_q, num_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] ulen_q, ulen_d;
  logic [31:0] srv_q, srv_d;

  logic [31:0] lane;
  logic [31:0] len_full, ulen_full;
  logic [3:0]  fmt;
  logic        full2, full4;
  logic        pay_v, pay_src, err, done, after_id, after_uri;
  nsd_rec_t    pay_rec, fin_rec;

  always_comb begin
    phase_d  = phase_q;
    mask_d   = mask_q;
    cnt_d    = cnt_q;
    ns_d     = ns_q;
    num_d    = num_q;
    len_d    = len_q;
    kind_d   = kind_q;
    ulen_d   = ulen_q;
    srv_d    = srv_q;
    pay_v    = 1'b0;
    pay_src  = 1'b0;
    err      = 1'b0;
    done     = 1'b0;
    after_id = 1'b0;

    cur       = restart_i ? PH_MASK : phase_q;
    fmt       = data_byte_i[3:0];
    lane      = {24'd0, data_byte_i} << {cnt_q[1:0], 3'b000};
    cnt_inc   = cnt_q + 31'd1;
    cnt_dec   = (cnt_q != '0) ? cnt_q - 31'd1 : cnt_q;
    full2     = (cnt_inc >= 31'd2);
    full4     = (cnt_inc >= 31'd4);
    len_full  = len_q | lane;
    ulen_full = ulen_q | lane;

    unique case (cur)
      PH_MASK: begin
        if (fmt > FMT_OPAQUE || (fmt >= FMT_GUID && !cfg_i.extended)) begin
          err = 1'b1;
        end else begin
          mask_d = cfg_i.expanded ? data_byte_i : {4'd0, fmt};
          cnt_d  = '0;
          ns_d   = '0;
          num_d  = '0;
          len_d  = '0;
          ulen_d = '1;
          srv_d  = '0;
          unique case (fmt)
            FMT_TWO_BYTE: begin
              phase_d = PH_ID8;
              kind_d  = ID_NUMERIC;
            end
            FMT_FOUR_BYTE: begin
              phase_d = PH_NS8;
              kind_d  = ID_NUMERIC;
            end
            FMT_NUMERIC: begin
              phase_d = PH_NS16;
              kind_d  = ID_NUMERIC;
            end
            FMT_STRING: begin
              phase_d = PH_NS16;
              kind_d  = ID_STRING;
            end
            FMT_GUID: begin
              phase_d = PH_NS16;
              kind_d  = ID_GUID;
            end
            default: begin
              phase_d = PH_NS16;
              kind_d  = ID_OPAQUE;
            end
          endcase
        end
      end
      PH_ID8: begin
        num_d    = {24'd0, data_byte_i};
        after_id = 1'b1;
      end
      PH_NS8: begin
        ns_d    = {8'd0, data_byte_i};
        phase_d = PH_ID16;
        cnt_d   = '0;
      end
      PH_ID16: begin
        num_d = num_q | lane;
        if (full2) begin
          cnt_d    = '0;
          after_id = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_NS16: begin
        ns_d = ns_q | lane[15:0];
        if (full2) begin
          cnt_d = '0;
          case (mask_q[3:0])
            FMT_NUMERIC: phase_d = PH_ID32;
            FMT_STRING:  phase_d = PH_SLEN;
            FMT_GUID:    phase_d = PH_GUID;
            default:     phase_d = PH_OLEN;
          endcase
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_ID32: begin
        num_d = num_q | lane;
        if (full4) begin
          cnt_d    = '0;
          after_id = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_SLEN: begin
        len_d = len_full;
        if (!full4) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = '0;
          if (len_full[31]) begin
            len_d    = '1;
            after_id = 1'b1;
          end else if (len_full[30:0] > cfg_i.max_len) begin
            err = 1'b1;
          end else if (len_full == '0) begin
            after_id = 1'b1;
          end else begin
            cnt_d   = len_full[30:0];
            phase_d = PH_SDATA;
          end
        end
      end
      PH_OLEN: begin
        len_d = len_full;
        if (!full4) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = '0;
          if (len_full > OpaqueMaxLength) begin
            err = 1'b1;
          end else if (len_full == '0) begin
            after_id = 1'b1;
          end else begin
            cnt_d   = len_full[30:0];
            phase_d = PH_ODATA;
          end
        end
      end
      PH_GUID: begin
        pay_v = 1'b1;
        if (cnt_inc >= GuidLength) begin
          cnt_d    = '0;
          after_id = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_SDATA, PH_ODATA: begin
        pay_v = 1'b1;
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          after_id = 1'b1;
        end
      end
      PH_ULEN: begin
        ulen_d = ulen_full;
        if (!full4) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = '0;
          if (ulen_full[31]) begin
            ulen_d = '1;
            done   = 1'b0;
          end else if (ulen_full[30:0] > cfg_i.max_len) begin
            err = 1'b1;
          end else if (ulen_full != '0) begin
            cnt_d   = ulen_full[30:0];
            phase_d = PH_UDATA;
          end
        end
      end
      PH_UDATA: begin
        pay_v   = 1'b1;
        pay_src = 1'b1;
        cnt_d   = cnt_dec;
      end
      PH_SRV: begin
        srv_d = srv_q | lane;
        if (full4) begin
          cnt_d = '0;
          done  = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = PH_MASK;
        cnt_d   = '0;
      end
    endcase

    // URI length done (null, zero) or last URI byte leads to the server index, or to completion without one
    after_uri = 1'b0;
    if (cur == PH_ULEN && full4 && !err && (ulen_full[31] || ulen_full == '0)) begin
      after_uri = 1'b1;
    end
    if (cur == PH_UDATA && cnt_dec == '0) begin
      after_uri = 1'b1;
    end

    if (after_id) begin
      if (mask_q[FlagUri]) begin
        phase_d = PH_ULEN;
        cnt_d   = '0;
        ulen_d  = '0;
      end else begin
        after_uri = 1'b1;
      end
    end
    if (after_uri) begin
      if (mask_q[FlagServer]) begin
        phase_d = PH_SRV;
        cnt_d   = '0;
        srv_d   = '0;
      end else begin
        done = 1'b1;
      end
    end
    if (done || err) begin
      phase_d = PH_MASK;
      cnt_d   = '0;
    end

    pay_rec                = '0;
    pay_rec.kind           = KIND_PAYLOAD;
    pay_rec.payload_byte   = data_byte_i;
    pay_rec.payload_source = pay_src;
    pay_rec.id_kind        = kind_q;

    fin_rec = '0;
    if (err) begin
      fin_rec.kind = KIND_ERROR;
    end else begin
      fin_rec.kind       = KIND_DONE;
      fin_rec.id_kind    = kind_d;
      fin_rec.ns_index   = ns_d;
      fin_rec.numeric_id = num_d;
      fin_rec.id_length  = len_d;
      fin_rec.uri_length = ulen_d;
      fin_rec.srv_index  = srv_d;
    end

    push_n_o = accept_i ? ({1'b0, pay_v} + {1'b0, done || err}) : 2'd0;
    rec0_o   = pay_v ? pay_rec : fin_rec;
    rec1_o   = fin_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MASK;
      mask_q  <= '0;
      cnt_q   <= '0;
      ns_q    <= '0;
      num_q   <= '0;
      len_q   <= '0;
      kind_q  <= '0;
      ulen_q  <= '1;
      srv_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      ns_q    <= ns_d;
      num_q   <= num_d;
      len_q   <= len_d;
      kind_q  <= kind_d;
      ulen_q  <= ulen_d;
      srv_q   <= srv_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nsd_fifo.sv @@
// ----------------------------------------------------------------------------
// nsd_fifo
// Result queue; takes up to two records per cycle, gives one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_fifo #(
  parameter int unsigned Depth = nsd_pkg::ResultDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire nsd_pkg::nsd_rec_t rec0_i,
  input  wire nsd_pkg::nsd_rec_t rec1_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output logic                   valid_o,
  output nsd_pkg::nsd_rec_t      head_o
);
  import nsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nsd_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, wptr1, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wptr1   = bump(wptr_q);
    wptr_d  = (push_n_i == 2'd2) ? bump(wptr1) : (push_n_i == 2'd1) ? wptr1 : wptr_q;
    rptr_d  = pop_i ? bump(rptr_q) : rptr_q;
    count_d = count_q + CntW'(push_n_i) - CntW'(pop_i);
  end

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q > CntW'(Depth - 2));
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= rec0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr1] <= rec1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nsd_checker.sv @@
// ----------------------------------------------------------------------------
// nsd_checker
// Port-level checks of the NodeId decoder result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [1:0]         record_kind_o,
  input wire logic [7:0]         payload_byte_o,
  input wire logic [1:0]         identifier_kind_o,
  input wire logic [15:0]        ns_index_o,
  input wire logic [31:0]        numeric_id_o,
  input wire logic signed [31:0] identifier_length_o,
  input wire logic signed [31:0] uri_length_o,
  input wire logic [31:0]        srv_index_o
);
  import nsd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(record_kind_o))
    else $error("result dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_ERROR |->
      ns_index_o == 16'd0 && numeric_id_o == 32'd0 && srv_index_o == 32'd0
      && identifier_kind_o == ID_NUMERIC)
    else $error("error record carries nonzero fields");

  a_pay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_PAYLOAD |->
      ns_index_o == 16'd0 && srv_index_o == 32'd0 && uri_length_o == 32'sd0)
    else $error("payload record carries completion fields");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_DONE &&
      (identifier_kind_o == ID_NUMERIC || identifier_kind_o == ID_GUID) |->
      identifier_length_o == 32'sd0 && payload_byte_o == 8'd0)
    else $error("numeric or guid completion has a length");

endmodule

bind nodeid_binary_stream_decoder_core nsd_checker u_nsd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .record_kind_o       (record_kind_o),
  .payload_byte_o      (payload_byte_o),
  .identifier_kind_o   (identifier_kind_o),
  .ns_index_o          (ns_index_o),
  .numeric_id_o        (numeric_id_o),
  .identifier_length_o (identifier_length_o),
  .uri_length_o        (uri_length_o),
  .srv_index_o         (srv_index_o)
);

`default_nettype wire
